@@ hdl/wstq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wstq_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WORKERS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_BITS_DEF   = 16;

    // Fixed field widths of the item ports
    localparam int OPCODE_W = 2;
    localparam int WORKER_W = 3;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;
    localparam int SOURCE_W = 4;
    localparam int CFG_W    = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    // Command queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH_WORKER = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_GLOBAL = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FETCH       = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_PUSHED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OWN     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_GLOBAL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WORKER  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd5;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_REFUSE,
        CMD_PUSH_W,
        CMD_PUSH_G,
        CMD_FETCH
    } cmd_kind_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [WORKER_W-1:0] worker;
        cmd_kind_t           kind;
    } cmd_t;

    typedef struct packed {
        logic [SOURCE_W-1:0] source_queue;
        logic [HANDLE_W-1:0] task_out;
        logic [STATUS_W-1:0] status;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/wstq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wstq_front #(
    parameter int ACT_W = 4
) (
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // opcode [1:0], worker_index [4:2], task_handle [20:5]
    input  wire logic [wstq_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic [ACT_W-1:0]                   eff_act,
    input  wire logic                               fifo_full,
    output logic                                    cmd_push,
    output wstq_pkg::cmd_t                          cmd
);

    logic [wstq_pkg::OPCODE_W-1:0] opcode;
    logic [wstq_pkg::WORKER_W-1:0] worker;
    logic                          worker_ok;

    assign opcode    = s_tdata[wstq_pkg::OPCODE_W-1:0];
    assign worker    = s_tdata[wstq_pkg::OPCODE_W +: wstq_pkg::WORKER_W];
    assign worker_ok = (ACT_W'(worker) < eff_act);

    assign s_tready = !fifo_full;
    assign cmd_push = s_tvalid && !fifo_full;

    always_comb
    begin
        cmd.handle = s_tdata[wstq_pkg::OPCODE_W + wstq_pkg::WORKER_W +: wstq_pkg::HANDLE_W];
        cmd.worker = worker;
        unique case (opcode)
            wstq_pkg::OP_PUSH_WORKER: cmd.kind = worker_ok ? wstq_pkg::CMD_PUSH_W
                                                           : wstq_pkg::CMD_REFUSE;
            wstq_pkg::OP_PUSH_GLOBAL: cmd.kind = wstq_pkg::CMD_PUSH_G;
            wstq_pkg::OP_FETCH:       cmd.kind = worker_ok ? wstq_pkg::CMD_FETCH
                                                           : wstq_pkg::CMD_NONE;
            default:                  cmd.kind = wstq_pkg::CMD_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/wstq_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wstq_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire wstq_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output wstq_pkg::cmd_t      head
);

    localparam int PTR_W = $clog2(wstq_pkg::CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(wstq_pkg::CMD_FIFO_DEPTH + 1);

    wstq_pkg::cmd_t   entry_reg [wstq_pkg::CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(wstq_pkg::CMD_FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(wstq_pkg::CMD_FIFO_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(wstq_pkg::CMD_FIFO_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hdl/wstq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wstq_back #(
    parameter int MAX_WORKERS = wstq_pkg::MAX_WORKERS_DEF,
    parameter int QUEUE_DEPTH = wstq_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_BITS   = wstq_pkg::TASK_BITS_DEF,
    parameter int ACT_W       = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    input  wire wstq_pkg::cmd_t       cmd,
    output logic                      cmd_pop,
    input  wire logic [ACT_W-1:0]     eff_act,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output wstq_pkg::res_t            res
);

    localparam int NQ = MAX_WORKERS + 1;
    localparam int QW = $clog2(NQ);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int AW = $clog2(NQ * QUEUE_DEPTH);
    localparam logic [QW-1:0] GLOBAL_Q = QW'(MAX_WORKERS);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [PW-1:0] top_reg [NQ];
    logic [PW-1:0] bot_reg [NQ];

    logic [TASK_BITS-1:0] slot_mem [NQ * QUEUE_DEPTH];
    logic [TASK_BITS-1:0] rd_data_reg;

    logic           out_valid_reg, out_valid_next;
    wstq_pkg::res_t out_reg, out_next;
    wstq_pkg::res_t pend_reg, pend_next;

    logic [NQ-1:0] empty;
    logic [QW-1:0] w_q;
    logic          vic_found;
    logic [QW-1:0] vic_q;

    logic          start;
    logic [QW-1:0] sel_q;
    logic          do_push, do_pop, do_steal;
    logic [wstq_pkg::STATUS_W-1:0] sel_status;
    logic [wstq_pkg::SOURCE_W-1:0] sel_source;
    logic [PW-1:0] t_sel, b_sel, t_inc, b_inc, b_dec;
    logic          full;
    logic          wr_en, rd_en;
    logic [AW-1:0] base_addr, wr_addr, rd_addr;

    assign w_q = QW'(cmd.worker);

    always_comb
    begin
        for (int i = 0; i < NQ; i++)
        begin
            empty[i] = (top_reg[i] == bot_reg[i]);
        end
    end

    // Lowest-index active worker, other than the requester, with a handle
    always_comb
    begin
        vic_found = 1'b0;
        vic_q     = '0;
        for (int i = 0; i < MAX_WORKERS; i++)
        begin
            if (!vic_found && (ACT_W'(i) < eff_act) && (QW'(i) != w_q) && !empty[i])
            begin
                vic_found = 1'b1;
                vic_q     = QW'(i);
            end
        end
    end

    always_comb
    begin
        sel_q      = w_q;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        do_steal   = 1'b0;
        sel_status = wstq_pkg::ST_NONE;
        sel_source = '0;
        case (cmd.kind)
            wstq_pkg::CMD_PUSH_W:
            begin
                do_push    = 1'b1;
                sel_source = wstq_pkg::SOURCE_W'(w_q);
            end
            wstq_pkg::CMD_PUSH_G:
            begin
                sel_q      = GLOBAL_Q;
                do_push    = 1'b1;
                sel_source = wstq_pkg::SOURCE_W'(GLOBAL_Q);
            end
            wstq_pkg::CMD_FETCH:
            begin
                if (!empty[w_q])
                begin
                    do_pop     = 1'b1;
                    sel_status = wstq_pkg::ST_OWN;
                    sel_source = wstq_pkg::SOURCE_W'(w_q);
                end
                else if (!empty[GLOBAL_Q])
                begin
                    sel_q      = GLOBAL_Q;
                    do_steal   = 1'b1;
                    sel_status = wstq_pkg::ST_GLOBAL;
                    sel_source = wstq_pkg::SOURCE_W'(GLOBAL_Q);
                end
                else if (vic_found)
                begin
                    sel_q      = vic_q;
                    do_steal   = 1'b1;
                    sel_status = wstq_pkg::ST_WORKER;
                    sel_source = wstq_pkg::SOURCE_W'(vic_q);
                end
            end
            wstq_pkg::CMD_REFUSE:
            begin
                sel_status = wstq_pkg::ST_REFUSED;
            end
            default:
            begin
                sel_status = wstq_pkg::ST_NONE;
            end
        endcase
    end

    assign t_sel = top_reg[sel_q];
    assign b_sel = bot_reg[sel_q];
    assign t_inc = (t_sel == LAST_SLOT) ? '0 : t_sel + 1'b1;
    assign b_inc = (b_sel == LAST_SLOT) ? '0 : b_sel + 1'b1;
    assign b_dec = (b_sel == '0) ? LAST_SLOT : b_sel - 1'b1;
    assign full  = (b_inc == t_sel);

    assign start   = (state_reg == S_IDLE) && cmd_valid && (!out_valid_reg || res_ready);
    assign cmd_pop = start;

    assign wr_en     = start && do_push && !full;
    assign rd_en     = start && (do_pop || do_steal);
    assign base_addr = AW'(sel_q) * AW'(QUEUE_DEPTH);
    assign wr_addr   = base_addr + AW'(b_sel);
    assign rd_addr   = base_addr + (do_pop ? AW'(b_dec) : AW'(t_sel));

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        pend_next      = pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (do_pop || do_steal)
                    begin
                        // hold status and source until the slot read returns
                        pend_next.status       = sel_status;
                        pend_next.source_queue = sel_source;
                        pend_next.task_out     = '0;
                        state_next             = S_READ;
                    end
                    else
                    begin
                        out_valid_next        = 1'b1;
                        out_next.task_out     = '0;
                        out_next.source_queue = sel_source;
                        if (do_push)
                        begin
                            out_next.status = full ? wstq_pkg::ST_REFUSED
                                                   : wstq_pkg::ST_PUSHED;
                        end
                        else
                        begin
                            out_next.status = sel_status;
                        end
                    end
                end
            end
            S_READ:
            begin
                out_valid_next        = 1'b1;
                out_next.status       = pend_reg.status;
                out_next.source_queue = pend_reg.source_queue;
                out_next.task_out     = wstq_pkg::HANDLE_W'(rd_data_reg);
                state_next            = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NQ; i++)
            begin
                top_reg[i] <= '0;
                bot_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                bot_reg[sel_q] <= b_inc;
            end
            if (start && do_pop)
            begin
                bot_reg[sel_q] <= b_dec;
            end
            if (start && do_steal)
            begin
                top_reg[sel_q] <= t_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= TASK_BITS'(cmd.handle);
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

@@ hdl/work_stealing_task_queues.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A push answer passes the command queue and the back end's result register; a fetch also passes the slot read.
// Throughput: one push per cycle while results are taken; a fetch holds off the next command until
//   its slot read returns, set by the slot memory's registered read port in the back end.
// A 2-entry command queue lets input accept run ahead of the back end.
// Reset (rst_n low, async): all top/bottom pointers zero, active_workers 8,
//   queues empty; the slot memory is not cleared and needs no clearing pass.
module work_stealing_task_queues #(
    parameter int MAX_WORKERS = wstq_pkg::MAX_WORKERS_DEF,
    parameter int QUEUE_DEPTH = wstq_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_BITS   = wstq_pkg::TASK_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [wstq_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // opcode [1:0], worker_index [4:2], task_handle [20:5], zero [23:21]
    input  wire logic [wstq_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status [2:0], task_out [18:3], source_queue [22:19], zero [23]
    output logic [wstq_pkg::OUT_DATA_W-1:0]        m_tdata
);

    localparam int ACT_W = ($clog2(MAX_WORKERS + 1) > wstq_pkg::CFG_W)
                           ? $clog2(MAX_WORKERS + 1) : wstq_pkg::CFG_W;

    logic [wstq_pkg::CFG_W-1:0] active_workers_reg;
    logic [ACT_W-1:0]           cfg_ext;
    logic [ACT_W-1:0]           eff_act;

    logic           cmd_push, fifo_full, cmd_pop, cmd_valid;
    wstq_pkg::cmd_t front_cmd, head_cmd;
    wstq_pkg::res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_workers_reg <= wstq_pkg::ACTIVE_RESET;
        end
        else if (cfg_valid)
        begin
            active_workers_reg <= cfg_data;
        end
    end

    // clamp the active count into 1..MAX_WORKERS
    assign cfg_ext = ACT_W'(active_workers_reg);
    assign eff_act = (cfg_ext == '0) ? ACT_W'(1)
                   : (cfg_ext > ACT_W'(MAX_WORKERS)) ? ACT_W'(MAX_WORKERS) : cfg_ext;

    wstq_front #(
        .ACT_W (ACT_W)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .eff_act   (eff_act),
        .fifo_full (fifo_full),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    wstq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_cmd  (front_cmd),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .head      (head_cmd)
    );

    wstq_back #(
        .MAX_WORKERS (MAX_WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TASK_BITS   (TASK_BITS),
        .ACT_W       (ACT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .eff_act   (eff_act),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {1'b0, res};

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command queue popped while empty");

    a_status_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.status <= wstq_pkg::ST_NONE))
        else $error("result status out of range");

    a_task_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res.status == wstq_pkg::ST_PUSHED || res.status == wstq_pkg::ST_REFUSED
                      || res.status == wstq_pkg::ST_NONE)) |-> (res.task_out == '0))
        else $error("task handle set on a result without a fetched handle");

    a_empty_source : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.status == wstq_pkg::ST_NONE) |-> (res.source_queue == '0))
        else $error("source set on an empty fetch");

endmodule

`default_nettype wire
